>>> sv/gpioadc_pkg.sv
// Shared types and constants of the GPIO / ADC expander register file.
// Used by gpioadc_pin_lock, gpioadc_core, gpio_adc_expander_registers and tb_top.
// No dependencies.
package gpioadc_pkg;

  localparam int NUM_PINS    = 16;
  localparam int NUM_CHANS   = 8;
  localparam int MAP_BITS    = 4 * NUM_PINS;
  localparam int CHAN_BITS   = $clog2(NUM_CHANS);

  // Request codes
  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_POINTER = 2'd1;
  localparam logic [1:0] REQ_READ    = 2'd2;
  localparam logic [1:0] REQ_DONE    = 2'd3;

  // Register map
  localparam logic [7:0] ADDR_DIR_A      = 8'h00;
  localparam logic [7:0] ADDR_DIR_B      = 8'h01;
  localparam logic [7:0] ADDR_GPIO_A     = 8'h12;
  localparam logic [7:0] ADDR_GPIO_B     = 8'h13;
  localparam logic [3:0] ADDR_ADC_NIBBLE = 4'h2;   // 0x20..0x2F data bytes
  localparam logic [7:0] ADDR_ADC_CFG    = 8'h30;
  localparam logic [7:0] ADDR_ADC_STATUS = 8'h31;

  // One bus request word
  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  reg_addr;
    logic [7:0]  write_data;
    logic [15:0] pin_levels;
    logic [15:0] adc_value;
  } req_t;

  // One result word
  typedef struct packed {
    logic [7:0]           read_data;
    logic [15:0]          pin_mode;
    logic [15:0]          pin_drive;
    logic [7:0]           channel_active;
    logic                 conv_start;
    logic [CHAN_BITS-1:0] conv_channel;
  } res_t;

endpackage

>>> sv/gpioadc_pin_lock.sv
// Per-pin lock mask: a pin is locked when it maps to an enabled ADC channel.
// Depends on gpioadc_pkg.
module gpioadc_pin_lock (
  input  logic [gpioadc_pkg::MAP_BITS-1:0]  pin_map,
  input  logic [gpioadc_pkg::NUM_CHANS-1:0] chan_en,
  output logic [gpioadc_pkg::NUM_PINS-1:0]  locked
);
  import gpioadc_pkg::*;

  // Each pin looks up its own map nibble independently
  always_comb begin
    for (int p = 0; p < NUM_PINS; p++) begin
      locked[p] = pin_map[4*p+3] & chan_en[pin_map[4*p +: CHAN_BITS]];
    end
  end

endmodule

>>> sv/gpioadc_core.sv
// Register state and single-pass request logic of the expander.
// Depends on gpioadc_pkg and gpioadc_pin_lock.
module gpioadc_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [gpioadc_pkg::MAP_BITS-1:0] cfg_wr_data,
  input  logic                             proc,      // request word consumed this cycle
  input  gpioadc_pkg::req_t                req,
  output gpioadc_pkg::res_t                res
);
  import gpioadc_pkg::*;

  logic [MAP_BITS-1:0]  map_r;
  logic [15:0]          dir_r, dir_nxt;
  logic [15:0]          mode_r, mode_nxt;
  logic [15:0]          drive_r, drive_nxt;
  logic [7:0]           enable_r, enable_nxt;
  logic [7:0]           active_r, active_nxt;
  logic [15:0]          result_r, result_nxt;
  logic                 busy_r, busy_nxt;
  logic [7:0]           ptr_r, ptr_nxt;
  logic [NUM_PINS-1:0]  locked;
  logic [7:0]           rd_byte;
  logic                 start;
  logic [CHAN_BITS-1:0] chan;

  gpioadc_pin_lock u_lock (
    .pin_map (map_r),
    .chan_en (enable_r),
    .locked  (locked)
  );

  // Read mux on the current pointer
  always_comb begin
    rd_byte = 8'd0;
    case (ptr_r)
      ADDR_DIR_A:      rd_byte = dir_r[7:0];
      ADDR_DIR_B:      rd_byte = dir_r[15:8];
      ADDR_GPIO_A:     rd_byte = req.pin_levels[7:0];
      ADDR_GPIO_B:     rd_byte = req.pin_levels[15:8];
      ADDR_ADC_CFG:    rd_byte = enable_r;
      ADDR_ADC_STATUS: rd_byte = {7'd0, busy_r};
      default: begin
        if (ptr_r[7:4] == ADDR_ADC_NIBBLE) begin
          rd_byte = ptr_r[0] ? result_r[7:0] : result_r[15:8];
        end
      end
    endcase
  end

  // Conversion start on pointer to a high data byte
  assign chan  = req.reg_addr[CHAN_BITS:1];
  assign start = (req.req_type == REQ_POINTER) &&
                 (req.reg_addr[7:4] == ADDR_ADC_NIBBLE) && !req.reg_addr[0] &&
                 (ptr_r != ADDR_ADC_STATUS) && enable_r[chan];

  // Next state
  always_comb begin
    dir_nxt    = dir_r;
    mode_nxt   = mode_r;
    drive_nxt  = drive_r;
    enable_nxt = enable_r;
    active_nxt = active_r;
    result_nxt = result_r;
    busy_nxt   = busy_r;
    ptr_nxt    = ptr_r;
    case (req.req_type)
      REQ_WRITE: begin
        case (req.reg_addr)
          ADDR_DIR_A: begin
            dir_nxt[7:0]  = req.write_data;
            mode_nxt[7:0] = (mode_r[7:0] & locked[7:0]) | (req.write_data & ~locked[7:0]);
          end
          ADDR_DIR_B: begin
            dir_nxt[15:8]  = req.write_data;
            mode_nxt[15:8] = (mode_r[15:8] & locked[15:8]) |
                             (req.write_data & ~locked[15:8]);
          end
          ADDR_GPIO_A:  drive_nxt[7:0]  = req.write_data;
          ADDR_GPIO_B:  drive_nxt[15:8] = req.write_data;
          ADDR_ADC_CFG: begin
            enable_nxt = req.write_data;
            active_nxt = active_r | req.write_data;
          end
          default: ;
        endcase
      end
      REQ_POINTER: begin
        ptr_nxt = req.reg_addr;
        if (start) begin
          busy_nxt = 1'b1;
        end
      end
      REQ_DONE: begin
        result_nxt = req.adc_value;
        busy_nxt   = 1'b0;
      end
      default: ;
    endcase
  end

  // Result word reflects state after the request
  always_comb begin
    res.read_data      = (req.req_type == REQ_READ) ? rd_byte : 8'd0;
    res.pin_mode       = mode_nxt;
    res.pin_drive      = drive_nxt;
    res.channel_active = active_nxt;
    res.conv_start     = start;
    res.conv_channel   = start ? chan : '0;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r    <= '0;
      dir_r    <= '0;
      mode_r   <= '0;
      drive_r  <= '0;
      enable_r <= '0;
      active_r <= '0;
      result_r <= '0;
      busy_r   <= 1'b0;
      ptr_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        map_r <= cfg_wr_data;
      end
      if (proc) begin
        dir_r    <= dir_nxt;
        mode_r   <= mode_nxt;
        drive_r  <= drive_nxt;
        enable_r <= enable_nxt;
        active_r <= active_nxt;
        result_r <= result_nxt;
        busy_r   <= busy_nxt;
        ptr_r    <= ptr_nxt;
      end
    end
  end

  // Enabled channels are always marked active (analog mode)
  a_enable_in_active: assert property (@(posedge clk) disable iff (!rst_n)
    (enable_r & ~active_r) == 8'd0)
    else $error("enabled channel not marked active");

  // A started conversion leaves the status busy
  a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    proc && start |=> busy_r)
    else $error("conversion start did not set busy");

  // Analog mode is never dropped by a request
  a_active_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    proc |=> (($past(active_r) & ~active_r) == 8'd0))
    else $error("analog active bit cleared");

endmodule

>>> sv/gpio_adc_expander_registers.sv
// Top level of the GPIO / ADC expander register file: input and result registers.
// Depends on gpioadc_pkg and gpioadc_core.
//
// One request word is taken every clock cycle while the result side keeps up;
// each word is registered on entry, handled in one pass of the register logic,
// and its result word then moves from the input register into the output register.
// The throughput figure is one word per cycle, bounded only by out_stall: the input
// register empties into the result register whenever that register is free or
// being taken, so in_stall rises only when both hold a word and the result is
// stalled. The user must write the pin-to-channel map (cfg_wr_en / cfg_wr_data)
// only while no request is in flight; the block does not check this. No read-back.
module gpio_adc_expander_registers (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [gpioadc_pkg::MAP_BITS-1:0]      cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            in_req_type,
  input  logic [7:0]                            in_reg_addr,
  input  logic [7:0]                            in_write_data,
  input  logic [15:0]                           in_pin_levels,
  input  logic [15:0]                           in_adc_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [7:0]                            out_read_data,
  output logic [15:0]                           out_pin_mode,
  output logic [15:0]                           out_pin_drive,
  output logic [7:0]                            out_channel_active,
  output logic                                  out_conv_start,
  output logic [gpioadc_pkg::CHAN_BITS-1:0]     out_conv_channel
);
  import gpioadc_pkg::*;

  logic  s1_valid_r;
  req_t  s1_req_r;
  logic  out_valid_r;
  res_t  out_res_r;
  res_t  res_nxt;
  logic  advance;
  logic  in_take;

  // Handshake: stage 1 moves on when the result register is free or taken
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  gpioadc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .proc        (advance),
    .req         (s1_req_r),
    .res         (res_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r.req_type   <= in_req_type;
      s1_req_r.reg_addr   <= in_reg_addr;
      s1_req_r.write_data <= in_write_data;
      s1_req_r.pin_levels <= in_pin_levels;
      s1_req_r.adc_value  <= in_adc_value;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_res_r.read_data;
  assign out_pin_mode       = out_res_r.pin_mode;
  assign out_pin_drive      = out_res_r.pin_drive;
  assign out_channel_active = out_res_r.channel_active;
  assign out_conv_start     = out_res_r.conv_start;
  assign out_conv_channel   = out_res_r.conv_channel;

  // A handled word always lands in the result register
  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("handled word lost");

  // Input stalls only with a full input register and a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("spurious input stall");

  // Channel field is quiet when no conversion starts
  a_chan_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.conv_start |-> out_res_r.conv_channel == '0)
    else $error("conversion channel set without start");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the GPIO / ADC expander register file.
// It drives request words, predicts each result word and checks the outputs.
// Depends on gpioadc_pkg and gpio_adc_expander_registers.
`timescale 1ns / 100ps

module tb_top;
  import gpioadc_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int WORDS_PER_PH = 220;

  typedef enum logic [1:0] {
    STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS
  } stall_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [MAP_BITS-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_req_type = '0;
  logic [7:0] in_reg_addr = '0;
  logic [7:0] in_write_data = '0;
  logic [15:0] in_pin_levels = '0;
  logic [15:0] in_adc_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_read_data;
  logic [15:0] out_pin_mode;
  logic [15:0] out_pin_drive;
  logic [7:0] out_channel_active;
  logic out_conv_start;
  logic [CHAN_BITS-1:0] out_conv_channel;

  gpio_adc_expander_registers u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_reg_addr        (in_reg_addr),
    .in_write_data      (in_write_data),
    .in_pin_levels      (in_pin_levels),
    .in_adc_value       (in_adc_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_read_data      (out_read_data),
    .out_pin_mode       (out_pin_mode),
    .out_pin_drive      (out_pin_drive),
    .out_channel_active (out_channel_active),
    .out_conv_start     (out_conv_start),
    .out_conv_channel   (out_conv_channel)
  );

  always #1 clk = ~clk;

  // Shadow of the register file
  logic [MAP_BITS-1:0] pin_map = '0;
  logic [15:0] dir_shadow = '0;
  logic [15:0] mode_shadow = '0;
  logic [15:0] drive_shadow = '0;
  logic [7:0] chan_en_shadow = '0;
  logic [7:0] analog_shadow = '0;
  logic [15:0] sample_shadow = '0;
  logic busy_shadow = 1'b0;
  logic [7:0] ptr_shadow = '0;

  req_t pending_words[$];
  res_t expected_results[$];
  int backlog = 0;
  int fail_count = 0;
  int cycle_count = 0;
  logic word_taken = 1'b0;

  // Sender burst / gap bookkeeping
  int burst_left = 1;
  int gap_left = 0;

  // Receiver stall pattern
  stall_kind_t stall_kind = STALL_NONE;
  int stall_run = 0;

  req_t req_seen;
  res_t res_seen;
  res_t res_want;
  res_t res_pred;

  // Applies one request word to the shadow and returns its result word
  task automatic regfile_step(input req_t w, output res_t r);
    logic [3:0] entry;
    logic [2:0] ch;
    int pin;
    r = '0;
    case (w.req_type)
      REQ_WRITE: begin
        case (w.reg_addr)
          ADDR_DIR_A, ADDR_DIR_B: begin
            // pins of an enabled channel keep their mode
            for (int b = 0; b < 8; b++) begin
              pin = b + ((w.reg_addr == ADDR_DIR_B) ? 8 : 0);
              entry = pin_map[4*pin +: 4];
              if (!(entry[3] && chan_en_shadow[entry[2:0]]))
                mode_shadow[pin] = w.write_data[b];
            end
            if (w.reg_addr == ADDR_DIR_B) dir_shadow[15:8] = w.write_data;
            else dir_shadow[7:0] = w.write_data;
          end
          ADDR_GPIO_A: drive_shadow[7:0] = w.write_data;
          ADDR_GPIO_B: drive_shadow[15:8] = w.write_data;
          ADDR_ADC_CFG: begin
            // analog mode is sticky once set
            analog_shadow = analog_shadow | w.write_data;
            chan_en_shadow = w.write_data;
          end
          default: ;
        endcase
      end
      REQ_POINTER: begin
        if (w.reg_addr[7:4] == ADDR_ADC_NIBBLE && !w.reg_addr[0]) begin
          ch = w.reg_addr[3:1];
          if (ptr_shadow != ADDR_ADC_STATUS && chan_en_shadow[ch]) begin
            busy_shadow = 1'b1;
            r.conv_start = 1'b1;
            r.conv_channel = ch;
          end
        end
        ptr_shadow = w.reg_addr;
      end
      REQ_READ: begin
        if (ptr_shadow[7:4] == ADDR_ADC_NIBBLE)
          r.read_data = ptr_shadow[0] ? sample_shadow[7:0] : sample_shadow[15:8];
        else begin
          case (ptr_shadow)
            ADDR_DIR_A:      r.read_data = dir_shadow[7:0];
            ADDR_DIR_B:      r.read_data = dir_shadow[15:8];
            ADDR_GPIO_A:     r.read_data = w.pin_levels[7:0];
            ADDR_GPIO_B:     r.read_data = w.pin_levels[15:8];
            ADDR_ADC_CFG:    r.read_data = chan_en_shadow;
            ADDR_ADC_STATUS: r.read_data = {7'd0, busy_shadow};
            default:         r.read_data = '0;
          endcase
        end
      end
      default: begin
        // conversion done, pending or not
        sample_shadow = w.adc_value;
        busy_shadow = 1'b0;
      end
    endcase
    r.pin_mode = mode_shadow;
    r.pin_drive = drive_shadow;
    r.channel_active = analog_shadow;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic add_word(input logic [1:0] kind, input logic [7:0] addr,
                          input logic [7:0] data, input logic [15:0] levels,
                          input logic [15:0] adc);
    req_t w;
    w.req_type = kind;
    w.reg_addr = addr;
    w.write_data = data;
    w.pin_levels = levels;
    w.adc_value = adc;
    pending_words.push_back(w);
    backlog++;
  endtask

  // Mostly well-formed accesses with random content, some plain noise
  function automatic req_t random_word();
    req_t w;
    int pick;
    w.req_type = REQ_WRITE;
    w.reg_addr = ADDR_DIR_A;
    w.write_data = 8'($urandom);
    w.pin_levels = 16'($urandom);
    w.adc_value = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      case ($urandom_range(0, 4))
        0: w.reg_addr = ADDR_DIR_A;
        1: w.reg_addr = ADDR_DIR_B;
        2: w.reg_addr = ADDR_GPIO_A;
        3: w.reg_addr = ADDR_GPIO_B;
        default: w.reg_addr = ADDR_ADC_CFG;
      endcase
    end else if (pick < 45) begin
      w.req_type = REQ_POINTER;
      case ($urandom_range(0, 5))
        0, 1, 2: w.reg_addr = {ADDR_ADC_NIBBLE, 3'($urandom), 1'b0};
        3: w.reg_addr = {ADDR_ADC_NIBBLE, 4'($urandom)};
        4: w.reg_addr = ADDR_ADC_STATUS;
        default: begin
          case ($urandom_range(0, 4))
            0: w.reg_addr = ADDR_DIR_A;
            1: w.reg_addr = ADDR_DIR_B;
            2: w.reg_addr = ADDR_GPIO_A;
            3: w.reg_addr = ADDR_GPIO_B;
            default: w.reg_addr = ADDR_ADC_CFG;
          endcase
        end
      endcase
    end else if (pick < 70) begin
      w.req_type = REQ_READ;
      w.reg_addr = 8'($urandom);
    end else if (pick < 85) begin
      w.req_type = REQ_DONE;
      w.reg_addr = 8'($urandom);
    end else begin
      w.req_type = 2'($urandom);
      w.reg_addr = 8'($urandom);
    end
    return w;
  endfunction

  // Map writes only happen with nothing in flight
  task automatic write_pin_map(input logic [MAP_BITS-1:0] m);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    pin_map = m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (backlog != 0 || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Driver: presents queued words in bursts, holds a word while stalled
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        req_seen = pending_words.pop_front();
        in_valid <= 1'b1;
        in_req_type <= req_seen.req_type;
        in_reg_addr <= req_seen.reg_addr;
        in_write_data <= req_seen.write_data;
        in_pin_levels <= req_seen.pin_levels;
        in_adc_value <= req_seen.adc_value;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 3))
            0: gap_left = 0;
            1: gap_left = 1;
            2: gap_left = $urandom_range(1, 4);
            default: gap_left = $urandom_range(5, 12);
          endcase
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, changing character after each random run
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_kind = stall_kind_t'($urandom_range(0, 3));
      stall_run = $urandom_range(16, 96);
    end else begin
      stall_run--;
    end
    case (stall_kind)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ($urandom_range(0, 15) == 0) ? ~out_stall : out_stall;
    endcase
  end

  // Monitor: checks result words, then predicts for the word taken this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        res_seen.read_data = out_read_data;
        res_seen.pin_mode = out_pin_mode;
        res_seen.pin_drive = out_pin_drive;
        res_seen.channel_active = out_channel_active;
        res_seen.conv_start = out_conv_start;
        res_seen.conv_channel = out_conv_channel;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %h", $time, res_seen);
          fail_count++;
        end else begin
          res_want = expected_results.pop_front();
          check_field("read_data", 16'(res_want.read_data), 16'(res_seen.read_data));
          check_field("pin_mode", res_want.pin_mode, res_seen.pin_mode);
          check_field("pin_drive", res_want.pin_drive, res_seen.pin_drive);
          check_field("channel_active", 16'(res_want.channel_active),
                      16'(res_seen.channel_active));
          check_field("conv_start", 16'(res_want.conv_start), 16'(res_seen.conv_start));
          check_field("conv_channel", 16'(res_want.conv_channel),
                      16'(res_seen.conv_channel));
        end
      end
      if (in_valid && !in_stall) begin
        req_seen.req_type = in_req_type;
        req_seen.reg_addr = in_reg_addr;
        req_seen.write_data = in_write_data;
        req_seen.pin_levels = in_pin_levels;
        req_seen.adc_value = in_adc_value;
        regfile_step(req_seen, res_pred);
        expected_results.push_back(res_pred);
        backlog--;
      end
    end
    word_taken <= rst_n && in_valid && !in_stall;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus: directed phase, then random phases under different pin maps
  initial begin
    logic [MAP_BITS-1:0] maps [6];
    maps[0] = '0;
    maps[1] = '1;
    maps[2] = 64'h8888_8888_8888_8888;
    maps[3] = {$urandom, $urandom};
    maps[4] = {$urandom, $urandom} | 64'h8888_8888_8888_8888;
    maps[5] = {$urandom, $urandom};

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // pins 0..7 on channels 0..7, pin 8 on channel 7, rest plain GPIO
    write_pin_map(64'h0000_000F_FEDC_BA98);
    add_word(REQ_WRITE, ADDR_DIR_A, 8'hFF, 16'h0000, 16'h0000);
    add_word(REQ_WRITE, ADDR_DIR_B, 8'h5A, 16'hFFFF, 16'hFFFF);
    add_word(REQ_WRITE, ADDR_GPIO_A, 8'h00, 16'h0000, 16'h0000);
    add_word(REQ_WRITE, ADDR_GPIO_B, 8'hFF, 16'h0000, 16'h0000);
    add_word(REQ_WRITE, ADDR_ADC_CFG, 8'h0F, 16'h0000, 16'h0000);
    // locked pins keep their mode
    add_word(REQ_WRITE, ADDR_DIR_A, 8'h00, 16'h0000, 16'h0000);
    // disable all but channel 0; analog mode stays
    add_word(REQ_WRITE, ADDR_ADC_CFG, 8'h01, 16'h0000, 16'h0000);
    add_word(REQ_WRITE, ADDR_DIR_A, 8'h00, 16'h0000, 16'h0000);
    // start, then status read while busy
    add_word(REQ_POINTER, 8'h20, 8'h00, 16'h0000, 16'h0000);
    add_word(REQ_POINTER, ADDR_ADC_STATUS, 8'h00, 16'h0000, 16'h0000);
    add_word(REQ_READ, 8'h00, 8'h00, 16'h0000, 16'h0000);
    // no start straight after status, restart while busy
    add_word(REQ_POINTER, 8'h20, 8'h00, 16'h0000, 16'h0000);
    add_word(REQ_POINTER, 8'h20, 8'h00, 16'h0000, 16'h0000);
    // disabled channel, low byte pointer: no start
    add_word(REQ_POINTER, 8'h22, 8'h00, 16'h0000, 16'h0000);
    add_word(REQ_POINTER, 8'h2F, 8'h00, 16'h0000, 16'h0000);
    add_word(REQ_DONE, 8'h00, 8'h00, 16'h0000, 16'hBE5A);
    add_word(REQ_READ, 8'h00, 8'h00, 16'h0000, 16'h0000);
    // live pin inputs, then an unmapped read
    add_word(REQ_POINTER, ADDR_GPIO_B, 8'h00, 16'h0000, 16'h0000);
    add_word(REQ_READ, 8'h00, 8'h00, 16'hA5C3, 16'h0000);
    add_word(REQ_POINTER, 8'hFF, 8'h00, 16'h0000, 16'h0000);
    add_word(REQ_READ, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    // read-only and unmapped writes are dropped
    add_word(REQ_WRITE, ADDR_ADC_STATUS, 8'hFF, 16'h0000, 16'h0000);
    add_word(REQ_WRITE, 8'hFF, 8'hFF, 16'h0000, 16'h0000);
    // channel 7 locks pins 7 and 8; done with nothing pending
    add_word(REQ_WRITE, ADDR_ADC_CFG, 8'h80, 16'h0000, 16'h0000);
    add_word(REQ_WRITE, ADDR_DIR_B, 8'h00, 16'h0000, 16'h0000);
    add_word(REQ_DONE, 8'h00, 8'h00, 16'h0000, 16'hFFFF);
    wait_drained();

    // sender pauses for a full drain between phases
    for (int ph = 0; ph < 6; ph++) begin
      write_pin_map(maps[ph]);
      for (int n = 0; n < WORDS_PER_PH; n++) begin
        pending_words.push_back(random_word());
        backlog++;
      end
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
